>>> rtl/sfpe_pkg.sv
package sfpe_pkg;

   // buffer geometry
   localparam int BUF_DEPTH = 32;
   localparam int CNT_W     = 6;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);

   // frame characters
   localparam logic [7:0] CH_OPEN  = 8'h3C;
   localparam logic [7:0] CH_TEXT  = 8'h40;
   localparam logic [7:0] CH_BIN   = 8'h21;
   localparam logic [7:0] CH_CLOSE = 8'h3E;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // reply characters
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   // reply job handed from parser to reply engine
   typedef struct packed {
      logic             binary;
      logic [CNT_W-1:0] count;
   } cmd_type;

   // "N/A-" prefix of a binary frame reply
   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0: ch = 8'h4E;
         2'd1: ch = 8'h2F;
         2'd2: ch = 8'h41;
         default: ch = 8'h2D;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/sfpe_ram.sv
module sfpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/sfpe_front.sv
module sfpe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   input  logic                  csr_write_en,
   input  logic [7:0]            csr_write_data,
   input  logic                  hold,
   output logic                  wr_en,
   output logic [sfpe_pkg::ADDR_W-1:0] wr_addr,
   output logic [7:0]            wr_data,
   output logic                  push,
   output sfpe_pkg::cmd_type     push_cmd
);
   import sfpe_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       echo_code_ff;
   logic             accept;
   logic [7:0]       b;

   assign req_ready = !hold;
   assign accept    = req_valid && req_ready;
   assign b         = req_rx_byte;
   assign wr_data   = b;

   // frame parser
   always_comb begin
      count_in = count_ff;
      type_in  = type_ff;
      cmd_in   = cmd_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[ADDR_W-1:0];
      push     = 1'b0;
      push_cmd.binary = (type_ff == CH_BIN);
      push_cmd.count  = count_ff;
      if (accept) begin
         priority if (count_ff == CNT_W'(0)) begin
            if (b == CH_OPEN) begin
               wr_en    = 1'b1;
               count_in = CNT_W'(1);
            end
         end else if (count_ff == CNT_W'(1)) begin
            if (b == CH_TEXT || b == CH_BIN) begin
               wr_en    = 1'b1;
               type_in  = b;
               count_in = CNT_W'(2);
            end else begin
               count_in = '0;
            end
         end else if (count_ff == CNT_W'(2)) begin
            if (b == CH_SPACE) begin
               wr_en    = 1'b1;
               count_in = CNT_W'(3);
            end else begin
               count_in = '0;
            end
         end else if (count_ff >= CNT_W'(BUF_DEPTH)) begin
            // buffer full: restart, a '<' opens a new frame
            wr_addr  = '0;
            count_in = '0;
            if (b == CH_OPEN) begin
               wr_en    = 1'b1;
               count_in = CNT_W'(1);
            end
         end else if (type_ff == CH_TEXT && b == CH_CLOSE) begin
            push     = (count_ff > CNT_W'(3)) && (cmd_ff == echo_code_ff);
            count_in = '0;
         end else if (type_ff == CH_BIN && count_ff > CNT_W'(3) &&
                      cmd_ff == 8'(count_ff)) begin
            push     = 1'b1;
            count_in = '0;
         end else begin
            wr_en = 1'b1;
            if (count_ff == CNT_W'(3)) begin
               cmd_in = b;
            end
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         echo_code_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_write_en) begin
            echo_code_ff <= csr_write_data;
         end
      end
      type_ff <= type_in;
      cmd_ff  <= cmd_in;
   end

endmodule

>>> rtl/sfpe_cmd_fifo.sv
module sfpe_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfpe_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              not_empty,
   output sfpe_pkg::cmd_type head
);
   import sfpe_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       do_push, do_pop;

   assign not_empty = (fill_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && (fill_ff != 2'd2);
   assign do_pop    = pop && not_empty;

   // two-entry job queue
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/sfpe_back.sv
module sfpe_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  sfpe_pkg::cmd_type     cmd,
   output logic                  pop,
   output logic [sfpe_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]            rd_data,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last
);
   import sfpe_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PREFIX, S_OPEN, S_FETCH, S_DATA, S_CLOSE, S_CR, S_LF
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       pre_ff, pre_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             out_free;

   assign out_free     = !valid_ff || rsp_ready;
   assign rd_addr      = idx_ff[ADDR_W-1:0];
   assign busy         = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

   // reply sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      pre_in   = pre_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               pop      = 1'b1;
               count_in = cmd.count;
               idx_in   = '0;
               pre_in   = '0;
               state_in = cmd.binary ? S_PREFIX : S_OPEN;
            end
         end
         S_PREFIX: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = prefix_char(pre_ff);
               last_in  = 1'b0;
               pre_in   = pre_ff + 2'd1;
               if (pre_ff == 2'd3) begin
                  state_in = S_OPEN;
               end
            end
         end
         S_OPEN: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = CH_LBRACK;
               last_in  = 1'b0;
               state_in = (count_ff == '0) ? S_CLOSE : S_FETCH;
            end
         end
         S_FETCH: begin
            // read address settles, data arrives next cycle
            state_in = S_DATA;
         end
         S_DATA: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = rd_data;
               last_in  = 1'b0;
               idx_in   = idx_ff + CNT_W'(1);
               state_in = (idx_ff + CNT_W'(1) == count_ff) ? S_CLOSE : S_FETCH;
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = CH_RBRACK;
               last_in  = 1'b0;
               state_in = S_CR;
            end
         end
         S_CR: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = CH_CR;
               last_in  = 1'b0;
               state_in = S_LF;
            end
         end
         S_LF: begin
            if (out_free) begin
               valid_in = 1'b1;
               byte_in  = CH_LF;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      idx_ff   <= idx_in;
      count_ff <= count_in;
      pre_ff   <= pre_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
   end

endmodule

>>> rtl/serial_frame_parser_echo_core.sv
// Serial frame parser with echo reply.
// req channel: one received byte per transfer on req_rx_byte (valid/ready).
// rsp channel: one reply byte per transfer on rsp_out_byte, rsp_last marks
//   the final LF of a reply (valid/ready).
// csr port: csr_write_en loads csr_write_data into the echo code register.
// Bytes that do not close a frame are taken one per cycle while req_ready
//   is high. A byte that closes a frame with a reply queues a job, which
//   passes through the job queue and the reply engine state register
//   before the first reply byte is loaded into the output register.
//   Unless rsp_ready stalls, the reply engine sends prefix and bracket
//   bytes one per cycle, and each stored byte after one frame buffer read.
// While a reply is queued or streaming, req_ready is low, since the frame
//   buffer is shared with the next frame; it rises the cycle after the LF
//   transfer.
// A stall on rsp_ready holds the output register and pauses the reply; no
//   byte is dropped or repeated.
// Reset (synchronous) empties the parser, the job queue and the output
//   register and clears the echo code; the frame buffer needs no clearing.
module serial_frame_parser_echo_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_write_en,
   input  logic [7:0] csr_write_data
);
   import sfpe_pkg::*;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              push, pop, q_not_empty, back_busy;
   cmd_type           push_cmd, head_cmd;

   // parser
   sfpe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .hold           (q_not_empty || back_busy),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // frame buffer
   sfpe_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // job queue
   sfpe_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   // reply engine
   sfpe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (q_not_empty),
      .cmd          (head_cmd),
      .pop          (pop),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .busy         (back_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
